// ----- rtl/hbmr_pkg.sv -----
`timescale 1ns / 1ps
package hbmr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 21;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MUL_W      = 2 * COORD_W;
  localparam int PROD_W     = DIFF_W + COORD_W;
  localparam int C_W        = MUL_W + 1;
  localparam int SAB_W      = PROD_W + 1;
  localparam int S_W        = SAB_W + 1;
  localparam int REM_W      = 6;
  // evaluator depth and the cell that takes the min on the way in
  localparam int EVAL_LAT   = 3;
  localparam int UPD_CELL   = MAX_POINTS - 1 - EVAL_LAT;
  localparam int PASS_LEN   = MAX_POINTS + EVAL_LAT;
  localparam int FC_W       = $clog2(PASS_LEN);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CNT_W-1:0]          best;
  } cell_t;

  typedef struct packed {
    logic             shift_en;
    logic             init_en;
    logic [CNT_W-1:0] init_val;
    logic [CNT_W-1:0] lo;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] a;
    logic signed [DIFF_W-1:0] b;
    logic signed [C_W-1:0]    c;
  } line_t;

  typedef struct packed {
    logic v;
    logic zero;
    logic pos;
  } side_t;

endpackage

// ----- rtl/hbmr_cell.sv -----
`timescale 1ns / 1ps
module hbmr_cell (
  input  logic              clk,
  input  hbmr_pkg::cell_ctl_t ctl,
  input  logic              upd_en,
  input  hbmr_pkg::cell_t   d_in,
  output hbmr_pkg::cell_t   d_out
);
  import hbmr_pkg::*;

  cell_t cell_r;

  always_ff @(posedge clk) begin
    if (ctl.init_en) begin
      cell_r.best <= ctl.init_val;
    end else if (ctl.shift_en) begin
      cell_r.x    <= d_in.x;
      cell_r.y    <= d_in.y;
      cell_r.best <= (upd_en && (d_in.best > ctl.lo)) ? ctl.lo : d_in.best;
    end
  end

  assign d_out = cell_r;

endmodule

// ----- rtl/hbmr_eval.sv -----
`timescale 1ns / 1ps
module hbmr_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            feed_v,
  input  logic signed [hbmr_pkg::COORD_W-1:0] x,
  input  logic signed [hbmr_pkg::COORD_W-1:0] y,
  input  hbmr_pkg::line_t                 line,
  output hbmr_pkg::side_t                 side
);
  import hbmr_pkg::*;

  logic signed [DIFF_W-1:0] a_s;
  logic signed [DIFF_W-1:0] b_s;
  logic signed [C_W-1:0]    c_s;
  logic signed [PROD_W-1:0] pa_r;
  logic signed [PROD_W-1:0] pb_r;
  logic signed [SAB_W-1:0]  sab_r;
  logic signed [S_W-1:0]    s;
  logic                     v1_r;
  logic                     v2_r;
  side_t                    side_r;

  assign a_s = line.a;
  assign b_s = line.b;
  assign c_s = line.c;
  assign s   = S_W'(sab_r) + S_W'(c_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      side_r <= '0;
    end else begin
      v1_r        <= feed_v;
      v2_r        <= v1_r;
      side_r.v    <= v2_r;
      side_r.zero <= (s == '0);
      side_r.pos  <= (s != '0) && !s[S_W-1];
    end
  end

  always_ff @(posedge clk) begin
    pa_r  <= PROD_W'(a_s) * PROD_W'(x);
    pb_r  <= PROD_W'(b_s) * PROD_W'(y);
    sab_r <= SAB_W'(pa_r) + SAB_W'(pb_r);
  end

  assign side = side_r;

endmodule

// ----- rtl/hull_boundary_min_removals_unit.sv -----
`timescale 1ns / 1ps
// Load: one point per cycle, in_ready high while idle; beats past 64 points are dropped.
// Compute: init, a capture pass over the ring, then for each of the P = n(n-1)/2 point pairs the
//   line steps and two ring rotations (64 cells plus 3 evaluator stages), one to count, one to update.
// Output: one beat per point in load order, once the ring has rotated that point to the head.
// Reset (rst_n low, synchronous): back to idle with an empty set; point storage is not cleared.
module hull_boundary_min_removals_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hbmr_pkg::COORD_W-1:0] in_px,
  input  logic signed [hbmr_pkg::COORD_W-1:0] in_py,
  input  logic                               in_set_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hbmr_pkg::REM_W-1:0]         out_removals,
  output logic                               out_result_end
);
  import hbmr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_CAP   = 3'd2;
  localparam logic [2:0] ST_LINE1 = 3'd3;
  localparam logic [2:0] ST_LINE2 = 3'd4;
  localparam logic [2:0] ST_CNT   = 3'd5;
  localparam logic [2:0] ST_UPD   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // Ring of cells: cell c takes from cell c+1, the tail takes a new point while
  // loading and the head otherwise. head_r is the point index sitting in cell 0.
  cell_t     cells [MAX_POINTS];
  cell_t     tail_in;
  cell_ctl_t ctl;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic [IDX_W-1:0] oc_r, oc_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             more_r, more_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] neg_r, neg_nxt;

  // captured pair and line through it
  logic signed [COORD_W-1:0] pix_r, piy_r, pjx_r, pjy_r;
  logic signed [MUL_W-1:0]   m1_r, m2_r;
  line_t                     line_r;

  logic       shift;
  logic       idx_ok;
  logic       feeding;
  logic       feed_v;
  logic       cap_win;
  side_t      side;
  logic [CNT_W-1:0] lo;

  assign idx_ok  = ({1'b0, head_r} < n_r);
  assign feeding = (fc_r < FC_W'(MAX_POINTS));
  assign feed_v  = ((state_r == ST_CNT) || (state_r == ST_UPD)) && feeding && idx_ok;
  assign cap_win = feeding && idx_ok &&
                   ((state_r == ST_CAP) || ((state_r == ST_UPD) && more_r));
  assign lo      = (pos_r < neg_r) ? pos_r : neg_r;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT) && (head_r == oc_r);
  assign out_removals   = cells[0].best[REM_W-1:0];
  assign out_result_end = (({1'b0, oc_r} + CNT_W'(1)) == n_r);

  always_comb begin
    unique case (state_r)
      ST_IDLE:  shift = in_valid && (n_r < CNT_W'(MAX_POINTS));
      ST_INIT:  shift = 1'b0;
      ST_OUT:   shift = !(out_valid && !out_ready);
      default:  shift = 1'b1;
    endcase
  end

  always_comb begin
    tail_in      = cells[0];
    if (state_r == ST_IDLE) begin
      tail_in.x    = in_px;
      tail_in.y    = in_py;
      tail_in.best = '0;
    end
    ctl.shift_en = shift;
    ctl.init_en  = (state_r == ST_INIT);
    ctl.init_val = (n_r == CNT_W'(1)) ? '0 : n_r;
    ctl.lo       = lo;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_ring
      if (g == MAX_POINTS - 1) begin : g_tail
        hbmr_cell u_cell (
          .clk    (clk),
          .ctl    (ctl),
          .upd_en (1'b0),
          .d_in   (tail_in),
          .d_out  (cells[g])
        );
      end else if (g == UPD_CELL) begin : g_upd
        // takes the min as the point whose evaluation just finished moves in
        hbmr_cell u_cell (
          .clk    (clk),
          .ctl    (ctl),
          .upd_en ((state_r == ST_UPD) && side.v && side.zero),
          .d_in   (cells[g+1]),
          .d_out  (cells[g])
        );
      end else begin : g_mid
        hbmr_cell u_cell (
          .clk    (clk),
          .ctl    (ctl),
          .upd_en (1'b0),
          .d_in   (cells[g+1]),
          .d_out  (cells[g])
        );
      end
    end
  endgenerate

  hbmr_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .feed_v (feed_v),
    .x      (cells[0].x),
    .y      (cells[0].y),
    .line   (line_r),
    .side   (side)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    head_nxt  = shift ? head_r + IDX_W'(1) : head_r;
    fc_nxt    = fc_r + FC_W'(1);
    oc_nxt    = oc_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    more_nxt  = more_r;
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (n_r < CNT_W'(MAX_POINTS)) begin
            n_nxt = n_r + CNT_W'(1);
          end
          if (in_set_end) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        fc_nxt = '0;
        oc_nxt = '0;
        i_nxt  = '0;
        j_nxt  = IDX_W'(1);
        state_nxt = (n_r == CNT_W'(1)) ? ST_OUT : ST_CAP;
      end
      ST_CAP: begin
        if (fc_r == FC_W'(MAX_POINTS - 1)) begin
          state_nxt = ST_LINE1;
        end
      end
      ST_LINE1: begin
        // step to the next pair while the current pair's line is being formed
        if (({1'b0, j_r} + CNT_W'(1)) < n_r) begin
          j_nxt    = j_r + IDX_W'(1);
          more_nxt = 1'b1;
        end else if (({1'b0, i_r} + CNT_W'(2)) < n_r) begin
          i_nxt    = i_r + IDX_W'(1);
          j_nxt    = i_r + IDX_W'(2);
          more_nxt = 1'b1;
        end else begin
          more_nxt = 1'b0;
        end
        state_nxt = ST_LINE2;
      end
      ST_LINE2: begin
        fc_nxt    = '0;
        pos_nxt   = '0;
        neg_nxt   = '0;
        state_nxt = ST_CNT;
      end
      ST_CNT: begin
        if (side.v && !side.zero) begin
          if (side.pos) begin
            pos_nxt = pos_r + CNT_W'(1);
          end else begin
            neg_nxt = neg_r + CNT_W'(1);
          end
        end
        if (fc_r == FC_W'(PASS_LEN - 1)) begin
          fc_nxt    = '0;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (fc_r == FC_W'(PASS_LEN - 1)) begin
          state_nxt = more_r ? ST_LINE1 : ST_OUT;
          oc_nxt    = '0;
        end
      end
      ST_OUT: begin
        if (out_valid && out_ready) begin
          oc_nxt = oc_r + IDX_W'(1);
          if (out_result_end) begin
            state_nxt = ST_IDLE;
            n_nxt     = '0;
            head_nxt  = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      head_r  <= '0;
      fc_r    <= '0;
      oc_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      more_r  <= 1'b0;
      pos_r   <= '0;
      neg_r   <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      head_r  <= head_nxt;
      fc_r    <= fc_nxt;
      oc_r    <= oc_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      more_r  <= more_nxt;
      pos_r   <= pos_nxt;
      neg_r   <= neg_nxt;
    end
  end

  // pair capture as the points go past the head, then the line: a, b, then c
  always_ff @(posedge clk) begin
    if (cap_win && (head_r == i_r)) begin
      pix_r <= cells[0].x;
      piy_r <= cells[0].y;
    end
    if (cap_win && (head_r == j_r)) begin
      pjx_r <= cells[0].x;
      pjy_r <= cells[0].y;
    end
    if (state_r == ST_LINE1) begin
      m1_r     <= MUL_W'(pjx_r) * MUL_W'(piy_r);
      m2_r     <= MUL_W'(pix_r) * MUL_W'(pjy_r);
      line_r.a <= DIFF_W'(pjy_r) - DIFF_W'(piy_r);
      line_r.b <= DIFF_W'(pix_r) - DIFF_W'(pjx_r);
    end
    if (state_r == ST_LINE2) begin
      line_r.c <= C_W'(m1_r) - C_W'(m2_r);
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("load and result beats overlap");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_side_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> ((pos_r + neg_r) <= n_r))
    else $error("side counts exceed point count");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, oc_r} < n_r))
    else $error("result index beyond the set");
`endif

endmodule
